/* src/tdbl_pkg.sv */
// shared types and constants for the tree distance engine
// no dependencies
`default_nettype none
package tdbl_pkg;
	localparam int NODE_W  = 10;
	localparam int LEVELS  = 11;
	localparam int LVL_W   = 4;
	localparam int DEPTH_W = 11;
	localparam int PATH_W  = 11;
	localparam int ANC_AW  = NODE_W + LVL_W;

	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef struct packed {
		logic              req_type;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} tdbl_req_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LD_DEP, ST_LD_ROW0, ST_LD_RD, ST_LD_WR,
		ST_Q_DA, ST_Q_DB, ST_Q_SWAP,
		ST_LF_ANC, ST_LF_DEP, ST_LF_CMP, ST_CHK,
		ST_MT_A, ST_MT_B, ST_MT_CMP,
		ST_FIN_ANC, ST_FIN_LCA, ST_FIN_DEP, ST_FIN_LEN, ST_OUT
	} tdbl_state_t;
endpackage
`default_nettype wire

/* src/tdbl_front.sv */
// front end: accepts request beats into a two-entry queue
// depends on tdbl_pkg
`default_nettype none
module tdbl_front (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      in_valid,
	output logic                     in_ready,
	input  wire tdbl_pkg::tdbl_req_t in_req,
	output logic                     q_valid,
	input  wire                      q_pop,
	output tdbl_pkg::tdbl_req_t      q_req
);
	import tdbl_pkg::*;

	tdbl_req_t   ent_q [2];
	logic        wr_ptr_q, rd_ptr_q;
	logic [1:0]  count_q;
	logic        push, pop;

	assign in_ready = (count_q != 2'd2);
	assign q_valid  = (count_q != 2'd0);
	assign q_req    = ent_q[rd_ptr_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_ptr_q] <= in_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end
endmodule
`default_nettype wire

/* src/tdbl_back.sv */
// back end: ancestor and depth memories, load and query sequencer, result register
// depends on tdbl_pkg
`default_nettype none
module tdbl_back (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               q_valid,
	output logic                              q_pop,
	input  wire tdbl_pkg::tdbl_req_t          q_req,
	output logic                              out_valid,
	input  wire                               out_ready,
	output logic [tdbl_pkg::PATH_W-1:0]       path_length,
	output logic [tdbl_pkg::NODE_W-1:0]       common_ancestor
);
	import tdbl_pkg::*;

	logic [NODE_W-1:0]  anc_mem [2**ANC_AW];
	logic [DEPTH_W-1:0] dep_mem [2**NODE_W];

	tdbl_state_t state_q, state_d;

	logic [NODE_W-1:0]  a_q, b_q, x_q, y_q, cur_q, up_q, ua_q, l_q, lca_q;
	logic [DEPTH_W-1:0] da_q, db_q, ydep_q;
	logic [PATH_W-1:0]  len_q, path_q;
	logic [LVL_W-1:0]   i_q;
	logic               out_valid_q;

	logic               anc_re, anc_we, dep_re, dep_we;
	logic [NODE_W-1:0]  anc_rnode, anc_wnode, dep_rnode, anc_wdata;
	logic [LVL_W-1:0]   anc_rlvl, anc_wlvl;
	logic [DEPTH_W-1:0] dep_wdata;
	logic [NODE_W-1:0]  anc_rd_q;
	logic [DEPTH_W-1:0] dep_rd_q;
	logic               anc_zero_q, dep_zero_q;
	logic [NODE_W-1:0]  anc_val;
	logic [DEPTH_W-1:0] dep_val;
	logic [DEPTH_W-1:0] db_now;

	// node 0 reads as the sentinel without any stored row
	assign anc_val = anc_zero_q ? '0 : anc_rd_q;
	assign dep_val = dep_zero_q ? '0 : dep_rd_q;
	assign db_now  = dep_val;

	always_ff @(posedge clk) begin
		if (anc_we) anc_mem[{anc_wnode, anc_wlvl}] <= anc_wdata;
		if (anc_re) begin
			anc_rd_q   <= anc_mem[{anc_rnode, anc_rlvl}];
			anc_zero_q <= (anc_rnode == '0);
		end
		if (dep_we) dep_mem[a_q] <= dep_wdata;
		if (dep_re) begin
			dep_rd_q   <= dep_mem[dep_rnode];
			dep_zero_q <= (dep_rnode == '0);
		end
	end

	always_comb begin
		state_d   = state_q;
		q_pop     = 1'b0;
		anc_re    = 1'b0;
		anc_we    = 1'b0;
		dep_re    = 1'b0;
		dep_we    = 1'b0;
		anc_rnode = x_q;
		anc_rlvl  = i_q;
		anc_wnode = a_q;
		anc_wlvl  = i_q;
		anc_wdata = anc_val;
		dep_rnode = a_q;
		dep_wdata = (dep_val == {DEPTH_W{1'b1}}) ? dep_val : dep_val + DEPTH_W'(1);
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop = 1'b1;
					if (q_req.req_type == REQ_QUERY) state_d = ST_Q_DA;
					else if (q_req.node_a != '0) state_d = ST_LD_DEP;
				end
			end
			ST_LD_DEP: begin
				dep_re    = 1'b1;
				dep_rnode = b_q;
			end
			ST_LD_ROW0: begin
				dep_we    = 1'b1;
				anc_we    = 1'b1;
				anc_wlvl  = '0;
				anc_wdata = b_q;
				state_d   = (LEVELS == 1) ? ST_IDLE : ST_LD_RD;
			end
			ST_LD_RD: begin
				anc_re    = 1'b1;
				anc_rnode = cur_q;
				anc_rlvl  = i_q - LVL_W'(1);
			end
			ST_LD_WR: begin
				anc_we  = 1'b1;
				state_d = (i_q == LVL_W'(LEVELS - 1)) ? ST_IDLE : ST_LD_RD;
			end
			ST_Q_DA: begin
				dep_re = 1'b1;
			end
			ST_Q_DB: begin
				dep_re    = 1'b1;
				dep_rnode = b_q;
			end
			ST_Q_SWAP: state_d = ST_LF_ANC;
			ST_LF_ANC: begin
				anc_re = 1'b1;
			end
			ST_LF_DEP: begin
				dep_re    = 1'b1;
				dep_rnode = anc_val;
			end
			ST_LF_CMP: state_d = (i_q == '0) ? ST_CHK : ST_LF_ANC;
			ST_CHK:    state_d = (x_q == y_q) ? ST_FIN_DEP : ST_MT_A;
			ST_MT_A: begin
				anc_re = 1'b1;
			end
			ST_MT_B: begin
				anc_re    = 1'b1;
				anc_rnode = y_q;
			end
			ST_MT_CMP: state_d = (i_q == '0) ? ST_FIN_ANC : ST_MT_A;
			ST_FIN_ANC: begin
				anc_re   = 1'b1;
				anc_rlvl = '0;
			end
			ST_FIN_LCA: state_d = ST_FIN_DEP;
			ST_FIN_DEP: begin
				dep_re    = 1'b1;
				dep_rnode = l_q;
			end
			ST_FIN_LEN: state_d = ST_OUT;
			ST_OUT: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
		// read states step straight on to their next state
		case (state_q)
			ST_LD_DEP:  state_d = ST_LD_ROW0;
			ST_LD_RD:   state_d = ST_LD_WR;
			ST_Q_DA:    state_d = ST_Q_DB;
			ST_Q_DB:    state_d = ST_Q_SWAP;
			ST_LF_ANC:  state_d = ST_LF_DEP;
			ST_LF_DEP:  state_d = ST_LF_CMP;
			ST_MT_A:    state_d = ST_MT_B;
			ST_MT_B:    state_d = ST_MT_CMP;
			ST_FIN_ANC: state_d = ST_FIN_LCA;
			ST_FIN_DEP: state_d = ST_FIN_LEN;
			default:    state_d = state_d;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_OUT && (!out_valid_q || out_ready)) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				a_q <= q_req.node_a;
				b_q <= q_req.node_b;
			end
			ST_LD_ROW0: begin
				cur_q <= b_q;
				i_q   <= LVL_W'(1);
			end
			ST_LD_WR: begin
				cur_q <= anc_val;
				i_q   <= i_q + LVL_W'(1);
			end
			ST_Q_DB: da_q <= dep_val;
			ST_Q_SWAP: begin
				db_q <= db_now;
				i_q  <= LVL_W'(LEVELS - 1);
				// deeper node goes to x
				if (da_q < db_now) begin
					x_q    <= b_q;
					y_q    <= a_q;
					ydep_q <= da_q;
				end else begin
					x_q    <= a_q;
					y_q    <= b_q;
					ydep_q <= db_now;
				end
			end
			ST_LF_DEP: up_q <= anc_val;
			ST_LF_CMP: begin
				if (dep_val >= ydep_q) x_q <= up_q;
				i_q <= i_q - LVL_W'(1);
			end
			ST_CHK: begin
				l_q <= x_q;
				i_q <= LVL_W'(LEVELS - 1);
			end
			ST_MT_B: ua_q <= anc_val;
			ST_MT_CMP: begin
				if (ua_q != anc_val) begin
					x_q <= ua_q;
					y_q <= anc_val;
				end
				i_q <= i_q - LVL_W'(1);
			end
			ST_FIN_LCA: l_q <= (anc_val == '0) ? NODE_W'(1) : anc_val;
			ST_FIN_LEN: len_q <= da_q + db_q - {dep_val[DEPTH_W-2:0], 1'b0};
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					path_q <= len_q;
					lca_q  <= l_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid       = out_valid_q;
	assign path_length     = path_q;
	assign common_ancestor = lca_q;
endmodule
`default_nettype wire

/* src/tree_distance_binary_lifting.sv */
// top level of the tree distance engine: request queue feeding the lifting sequencer
// depends on tdbl_pkg, tdbl_front, tdbl_back
//
// input channel (in_valid/in_ready) carries req_type, node_a, node_b.
// a load (req_type 0) stores node_a under parent node_b; parents must be
// loaded before their children. a query (req_type 1) returns one beat on the
// output channel (out_valid/out_ready) with path_length and common_ancestor.
// a two-entry queue takes beats while the sequencer works, so input is
// accepted until the queue fills.
// in the sequencer a load takes one memory read and one write per level.
// a query skips the meet levels when the lifted node already equals the
// other: each lift level needs an ancestor read, a depth read and a compare,
// each meet level two ancestor reads and a compare, all through the single
// read port of each memory.
// reset clears the queue, the sequencer and the output valid; node 0 reads as
// the sentinel, so no memory clearing pass is run.
// when the receiver stalls, the result waits in the output register and the
// sequencer holds the next result until that register frees up.
`default_nettype none
module tree_distance_binary_lifting (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	output logic                         in_ready,
	input  wire                          req_type,
	input  wire [tdbl_pkg::NODE_W-1:0]   node_a,
	input  wire [tdbl_pkg::NODE_W-1:0]   node_b,
	output logic                         out_valid,
	input  wire                          out_ready,
	output logic [tdbl_pkg::PATH_W-1:0]  path_length,
	output logic [tdbl_pkg::NODE_W-1:0]  common_ancestor
);
	import tdbl_pkg::*;

	tdbl_req_t in_req, q_req;
	logic      q_valid, q_pop;

	assign in_req.req_type = req_type;
	assign in_req.node_a   = node_a;
	assign in_req.node_b   = node_b;

	tdbl_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_req   (in_req),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_req    (q_req)
	);

	tdbl_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.q_valid         (q_valid),
		.q_pop           (q_pop),
		.q_req           (q_req),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.path_length     (path_length),
		.common_ancestor (common_ancestor)
	);
endmodule
`default_nettype wire

/* test/tdbl_checker.sv */
// checker for the tree distance engine: watches both channels, keeps its own
// ancestor table and depth file, predicts each query answer and compares
// depends on tdbl_pkg
`default_nettype none
module tdbl_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	input  wire                         in_ready,
	input  wire                         req_type,
	input  wire [tdbl_pkg::NODE_W-1:0]  node_a,
	input  wire [tdbl_pkg::NODE_W-1:0]  node_b,
	input  wire                         out_valid,
	input  wire                         out_ready,
	input  wire [tdbl_pkg::PATH_W-1:0]  path_length,
	input  wire [tdbl_pkg::NODE_W-1:0]  common_ancestor,
	output int                          err_count,
	output int                          pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import tdbl_pkg::*;

	typedef struct packed {
		logic [PATH_W-1:0] len;
		logic [NODE_W-1:0] lca;
	} answer_t;

	logic [NODE_W-1:0]  anc_tab [1024][LEVELS];
	logic [DEPTH_W-1:0] dep_tab [1024];
	answer_t            answers [$];

	function automatic void attach_node(int v, int p);
		int d;
		if (v == 0)
			return;
		d = int'(dep_tab[p]) + 1;
		if (d > 2047)
			d = 2047;
		dep_tab[v] = d[DEPTH_W-1:0];
		anc_tab[v][0] = p[NODE_W-1:0];
		for (int i = 1; i < LEVELS; i++)
			anc_tab[v][i] = anc_tab[anc_tab[v][i-1]][i-1];
	endfunction

	function automatic answer_t distance_of(int qa, int qb);
		int a, b, t, l, n;
		answer_t r;
		a = qa;
		b = qb;
		if (dep_tab[a] < dep_tab[b]) begin
			t = a; a = b; b = t;
		end
		for (int i = LEVELS - 1; i >= 0; i--) begin
			t = anc_tab[a][i];
			if (dep_tab[t] >= dep_tab[b])
				a = t;
		end
		if (a == b) begin
			l = a;
		end else begin
			for (int i = LEVELS - 1; i >= 0; i--) begin
				if (anc_tab[a][i] != anc_tab[b][i]) begin
					t = anc_tab[a][i];
					b = anc_tab[b][i];
					a = t;
				end
			end
			// trees that only meet at the sentinel report node 1
			l = anc_tab[a][0];
			if (l < 1)
				l = 1;
		end
		n = int'(dep_tab[qa]) + int'(dep_tab[qb]) - 2 * int'(dep_tab[l]);
		r.len = n[PATH_W-1:0];
		r.lca = l[NODE_W-1:0];
		return r;
	endfunction

	always @(posedge clk) begin
		answer_t want;
		if (!arst_n) begin
			for (int v = 0; v < 1024; v++) begin
				dep_tab[v] = '0;
				for (int i = 0; i < LEVELS; i++)
					anc_tab[v][i] = '0;
			end
			answers.delete();
			err_count = 0;
		end else begin
			if (in_valid && in_ready) begin
				if (req_type == REQ_QUERY)
					answers.insert(answers.size(), distance_of(node_a, node_b));
				else
					attach_node(node_a, node_b);
			end
			if (out_valid && out_ready) begin
				if (answers.size() == 0) begin
					err_count++;
					if (err_count <= 10)
						$display("unexpected result beat: len %0d lca %0d",
							path_length, common_ancestor);
				end else begin
					want = answers.pop_front();
					if (want.len !== path_length || want.lca !== common_ancestor) begin
						err_count++;
						if (err_count <= 10)
							$display("mismatch: len exp %0d got %0d, lca exp %0d got %0d",
								want.len, path_length, want.lca, common_ancestor);
					end
				end
			end
		end
		pending = answers.size();
	end
endmodule
`default_nettype wire

/* test/tree_distance_binary_lifting_tb.sv */
// top of the tree distance engine testbench: clock, reset, tree-shaped stimulus,
// random stalls on both sides and the verdict
// depends on tdbl_pkg, tree_distance_binary_lifting, tdbl_checker
`default_nettype none
module tree_distance_binary_lifting_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tdbl_pkg::*;

	localparam int STALL_LIMIT = 5000;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              req_type = REQ_LOAD;
	logic [NODE_W-1:0] node_a = '0;
	logic [NODE_W-1:0] node_b = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [PATH_W-1:0] path_length;
	logic [NODE_W-1:0] common_ancestor;
	int                err_count, pending;

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	logic hold_go = 1'b0;
	int   hold_left = 0;
	logic hold_done = 1'b0;
	int   quiet_cycles = 0;

	logic loaded [1024];
	int   tree_nodes [$];
	int   last_loaded;

	tree_distance_binary_lifting dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .node_a(node_a), .node_b(node_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.path_length(path_length), .common_ancestor(common_ancestor)
	);

	tdbl_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.req_type(req_type), .node_a(node_a), .node_b(node_b),
		.out_valid(out_valid), .out_ready(out_ready),
		.path_length(path_length), .common_ancestor(common_ancestor),
		.err_count(err_count), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus one long hold-off while the sender keeps going
	always @(posedge clk) begin
		if (hold_go && !hold_done && hold_left == 0) begin
			hold_left = 600;
			hold_done = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_beat(logic kind, int a, int b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= kind;
		node_a <= a[NODE_W-1:0];
		node_b <= b[NODE_W-1:0];
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic load_node(int v, int p);
		send_beat(REQ_LOAD, v, p);
		if (!loaded[v])
			tree_nodes.insert(tree_nodes.size(), v);
		loaded[v] = 1'b1;
		last_loaded = v;
	endtask

	task automatic random_items(int count);
		int v, p, a, b;
		for (int n = 0; n < count; n++) begin
			if ($urandom_range(99) < 40) begin
				v = $urandom_range(1023, 2);
				case ($urandom_range(9))
					0: p = 0;
					1, 2, 3: p = last_loaded;
					default: p = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
				endcase
				load_node(v, p);
			end else begin
				a = tree_nodes[$urandom_range(tree_nodes.size() - 1)];
				b = ($urandom_range(9) == 0) ? 0
					: tree_nodes[$urandom_range(tree_nodes.size() - 1)];
				send_beat(REQ_QUERY, a, b);
			end
		end
	endtask

	initial begin
		for (int v = 0; v < 1024; v++)
			loaded[v] = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: root, extreme node numbers, a separate root, queries with
		// node zero, equal nodes, and a reload that moves a subtree
		load_node(1, 0);
		load_node(1023, 1);
		load_node(512, 1023);
		load_node(2, 1);
		load_node(341, 512);
		load_node(682, 341);
		load_node(3, 0);
		load_node(4, 3);
		send_beat(REQ_QUERY, 1023, 2);
		send_beat(REQ_QUERY, 682, 2);
		send_beat(REQ_QUERY, 512, 512);
		send_beat(REQ_QUERY, 682, 0);
		send_beat(REQ_QUERY, 1, 0);
		send_beat(REQ_QUERY, 4, 682);
		send_beat(REQ_QUERY, 1, 1);
		send_beat(REQ_QUERY, 2, 1023);
		load_node(2, 682);
		send_beat(REQ_QUERY, 2, 1023);
		send_beat(REQ_QUERY, 341, 2);
		load_node(1023, 3);
		send_beat(REQ_QUERY, 512, 4);

		send_idle_pct = 38;
		recv_idle_pct = 49;
		hold_go = 1'b1;
		random_items(145);
		send_idle_pct = 49;
		recv_idle_pct = 38;
		random_items(145);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(145);
		in_valid <= 1'b0;

		while (pending != 0 || hold_left != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
`default_nettype wire
